/* src/prs_pkg.sv */
package prs_pkg;

    // status of the shared divider as seen by the sequencer
    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

endpackage

/* src/prs_divider.sv */
module prs_divider #(
    parameter int W = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic [2*W-1:0]       i_num,
    input  logic [W-1:0]         i_den,
    output logic [2*W-1:0]       o_quo,
    output logic [W-1:0]         o_rem,
    output prs_pkg::t_div_stat   o_stat
);
    import prs_pkg::*;

    localparam int CW = $clog2(2 * W + 1);

    logic [CW-1:0]  r_cnt, n_cnt;
    logic           r_busy, n_busy;
    logic           r_done, n_done;
    logic [W-1:0]   r_rem, n_rem;
    logic [2*W-1:0] r_quo, n_quo;
    logic [W-1:0]   r_den, n_den;

    logic [W:0]     rem_sh;
    logic [W:0]     diff;
    logic           ge;

    // restoring division, one quotient bit per cycle
    assign rem_sh = {r_rem, r_quo[2*W-1]};
    assign diff   = rem_sh - {1'b0, r_den};
    assign ge     = rem_sh >= {1'b0, r_den};

    always_comb begin
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        n_rem  = r_rem;
        n_quo  = r_quo;
        n_den  = r_den;
        if (i_start) begin
            n_cnt  = CW'(2 * W);
            n_busy = 1'b1;
            n_rem  = '0;
            n_quo  = i_num;
            n_den  = i_den;
        end else if (r_busy) begin
            n_rem = ge ? diff[W-1:0] : rem_sh[W-1:0];
            n_quo = {r_quo[2*W-2:0], ge};
            n_cnt = r_cnt - CW'(1);
            if (r_cnt == CW'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_rem <= n_rem;
        r_quo <= n_quo;
        r_den <= n_den;
    end

    assign o_quo       = r_quo;
    assign o_rem       = r_rem;
    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;

endmodule

/* src/primitive_root_search.sv */
// Run time is data dependent and paced by the divisions on the shared divider; a test item
// runs a totient pass, a gcd, a factoring of phi and a few
// square-and-multiply powers; search mode repeats the test for a = 2, 3, ... up to n-1.
// Throughput: one item at a time, busy stays high until the result strobe.
// o_valid marks the result for one cycle; the receiver cannot stall.
// Synchronous active-low reset returns the sequencer to idle and drops any item in flight.
module primitive_root_search #(
    parameter int WIDTH = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  logic             i_func,
    input  logic [WIDTH-1:0] i_modulus,
    input  logic [WIDTH-1:0] i_candidate,
    output logic             o_valid,
    output logic             o_is_gen,
    output logic [WIDTH-1:0] o_generator,
    output logic [WIDTH-1:0] o_totient
);
    import prs_pkg::*;

    localparam int SW = 5;
    localparam logic [SW-1:0] S_IDLE      = 5'd0;
    localparam logic [SW-1:0] S_TOT_SQ    = 5'd1;
    localparam logic [SW-1:0] S_TOT_CMP   = 5'd2;
    localparam logic [SW-1:0] S_TOT_DIV   = 5'd3;
    localparam logic [SW-1:0] S_TOT_SUB   = 5'd4;
    localparam logic [SW-1:0] S_TOT_LAST  = 5'd5;
    localparam logic [SW-1:0] S_GEN_BEGIN = 5'd6;
    localparam logic [SW-1:0] S_SRCH_NEXT = 5'd7;
    localparam logic [SW-1:0] S_GCD_INIT  = 5'd8;
    localparam logic [SW-1:0] S_GCD_LOOP  = 5'd9;
    localparam logic [SW-1:0] S_GCD_STEP  = 5'd10;
    localparam logic [SW-1:0] S_RED       = 5'd11;
    localparam logic [SW-1:0] S_FAC_SQ    = 5'd12;
    localparam logic [SW-1:0] S_FAC_CMP   = 5'd13;
    localparam logic [SW-1:0] S_FAC_DIV   = 5'd14;
    localparam logic [SW-1:0] S_EXP_SET   = 5'd15;
    localparam logic [SW-1:0] S_POW_LOOP  = 5'd16;
    localparam logic [SW-1:0] S_POW_RM    = 5'd17;
    localparam logic [SW-1:0] S_POW_RR    = 5'd18;
    localparam logic [SW-1:0] S_POW_BM    = 5'd19;
    localparam logic [SW-1:0] S_POW_BR    = 5'd20;
    localparam logic [SW-1:0] S_PASS      = 5'd21;
    localparam logic [SW-1:0] S_FAIL      = 5'd22;
    localparam logic [SW-1:0] S_WAIT      = 5'd23;

    logic [SW-1:0]      r_state, n_state;
    logic [SW-1:0]      r_ret, n_ret;
    logic               r_func, n_func;
    logic [WIDTH-1:0]   r_n, n_n;
    logic [WIDTH-1:0]   r_a, n_a;
    logic [WIDTH-1:0]   r_phi, n_phi;
    logic [WIDTH-1:0]   r_f, n_f;       // m during totient, f during factoring of phi
    logic [WIDTH-1:0]   r_p, n_p;       // trial divisor p / q
    logic               r_flag, n_flag;
    logic               r_tail, n_tail;
    logic [WIDTH-1:0]   r_x, n_x;
    logic [WIDTH-1:0]   r_y, n_y;
    logic [WIDTH-1:0]   r_ra, n_ra;     // candidate reduced mod n
    logic [WIDTH-1:0]   r_b, n_b;
    logic [WIDTH-1:0]   r_e, n_e;
    logic [WIDTH-1:0]   r_res, n_res;
    logic [2*WIDTH-1:0] r_prod;
    logic               r_valid, n_valid;
    logic               r_is_gen, n_is_gen;
    logic [WIDTH-1:0]   r_gen, n_gen;

    logic [WIDTH-1:0]   mul_x, mul_y;
    logic [2*WIDTH-1:0] mul_out;

    logic               div_go;
    logic [2*WIDTH-1:0] div_num;
    logic [WIDTH-1:0]   div_den;
    logic [2*WIDTH-1:0] div_quo_full;
    logic [WIDTH-1:0]   div_quo;
    logic [WIDTH-1:0]   div_rem;
    t_div_stat          div_stat;

    prs_divider #(
        .W (WIDTH)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_go),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_quo   (div_quo_full),
        .o_rem   (div_rem),
        .o_stat  (div_stat)
    );

    // quotients used here all fit in WIDTH bits
    assign div_quo = div_quo_full[WIDTH-1:0];
    assign mul_out = {{WIDTH{1'b0}}, mul_x} * {{WIDTH{1'b0}}, mul_y};

    always_comb begin
        n_state  = r_state;
        n_ret    = r_ret;
        n_func   = r_func;
        n_n      = r_n;
        n_a      = r_a;
        n_phi    = r_phi;
        n_f      = r_f;
        n_p      = r_p;
        n_flag   = r_flag;
        n_tail   = r_tail;
        n_x      = r_x;
        n_y      = r_y;
        n_ra     = r_ra;
        n_b      = r_b;
        n_e      = r_e;
        n_res    = r_res;
        n_valid  = 1'b0;
        n_is_gen = r_is_gen;
        n_gen    = r_gen;
        mul_x    = '0;
        mul_y    = '0;
        div_go   = 1'b0;
        div_num  = '0;
        div_den  = '0;

        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_func   = i_func;
                    n_n      = i_modulus;
                    n_a      = i_func ? WIDTH'(2) : i_candidate;
                    n_is_gen = 1'b0;
                    n_gen    = '0;
                    if (i_modulus < WIDTH'(2)) begin
                        n_phi   = WIDTH'(1);
                        n_state = S_GEN_BEGIN;
                    end else begin
                        n_phi   = i_modulus;
                        n_f     = i_modulus;
                        n_p     = WIDTH'(2);
                        n_state = S_TOT_SQ;
                    end
                end
            end
            // totient by trial division: r -= r/p for each prime p of n
            S_TOT_SQ: begin
                mul_x   = r_p;
                mul_y   = r_p;
                n_state = S_TOT_CMP;
            end
            S_TOT_CMP: begin
                if (r_prod <= {{WIDTH{1'b0}}, r_f}) begin
                    div_go  = 1'b1;
                    div_num = {{WIDTH{1'b0}}, r_f};
                    div_den = r_p;
                    n_flag  = 1'b0;
                    n_ret   = S_TOT_DIV;
                    n_state = S_WAIT;
                end else if (r_f > WIDTH'(1)) begin
                    div_go  = 1'b1;
                    div_num = {{WIDTH{1'b0}}, r_phi};
                    div_den = r_f;
                    n_ret   = S_TOT_LAST;
                    n_state = S_WAIT;
                end else begin
                    n_state = S_GEN_BEGIN;
                end
            end
            S_TOT_DIV: begin
                if (div_rem == '0) begin
                    n_f     = div_quo;
                    n_flag  = 1'b1;
                    div_go  = 1'b1;
                    div_num = {{WIDTH{1'b0}}, div_quo};
                    div_den = r_p;
                    n_ret   = S_TOT_DIV;
                    n_state = S_WAIT;
                end else if (r_flag) begin
                    div_go  = 1'b1;
                    div_num = {{WIDTH{1'b0}}, r_phi};
                    div_den = r_p;
                    n_ret   = S_TOT_SUB;
                    n_state = S_WAIT;
                end else begin
                    n_p     = r_p + WIDTH'(1);
                    n_state = S_TOT_SQ;
                end
            end
            S_TOT_SUB: begin
                n_phi   = r_phi - div_quo;
                n_p     = r_p + WIDTH'(1);
                n_state = S_TOT_SQ;
            end
            S_TOT_LAST: begin
                n_phi   = r_phi - div_quo;
                n_state = S_GEN_BEGIN;
            end
            S_GEN_BEGIN: begin
                n_state = r_func ? S_SRCH_NEXT : S_GCD_INIT;
            end
            S_SRCH_NEXT: begin
                if (r_a < r_n) begin
                    n_state = S_GCD_INIT;
                end else begin
                    n_gen   = '0;
                    n_valid = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_GCD_INIT: begin
                n_x     = r_a;
                n_y     = r_n;
                n_state = S_GCD_LOOP;
            end
            S_GCD_LOOP: begin
                if (r_y != '0) begin
                    div_go  = 1'b1;
                    div_num = {{WIDTH{1'b0}}, r_x};
                    div_den = r_y;
                    n_ret   = S_GCD_STEP;
                    n_state = S_WAIT;
                end else if (r_x != WIDTH'(1)) begin
                    n_state = S_FAIL;
                end else if (r_n < WIDTH'(2)) begin
                    n_state = S_PASS;
                end else begin
                    div_go  = 1'b1;
                    div_num = {{WIDTH{1'b0}}, r_a};
                    div_den = r_n;
                    n_ret   = S_RED;
                    n_state = S_WAIT;
                end
            end
            S_GCD_STEP: begin
                n_x     = r_y;
                n_y     = div_rem;
                n_state = S_GCD_LOOP;
            end
            S_RED: begin
                n_ra    = div_rem;
                n_f     = r_phi;
                n_p     = WIDTH'(2);
                n_state = S_FAC_SQ;
            end
            // walk the primes q of phi, check a^(phi/q) != 1
            S_FAC_SQ: begin
                mul_x   = r_p;
                mul_y   = r_p;
                n_state = S_FAC_CMP;
            end
            S_FAC_CMP: begin
                if (r_prod <= {{WIDTH{1'b0}}, r_f}) begin
                    div_go  = 1'b1;
                    div_num = {{WIDTH{1'b0}}, r_f};
                    div_den = r_p;
                    n_flag  = 1'b0;
                    n_ret   = S_FAC_DIV;
                    n_state = S_WAIT;
                end else if (r_f > WIDTH'(1)) begin
                    div_go  = 1'b1;
                    div_num = {{WIDTH{1'b0}}, r_phi};
                    div_den = r_f;
                    n_tail  = 1'b1;
                    n_ret   = S_EXP_SET;
                    n_state = S_WAIT;
                end else begin
                    n_state = S_PASS;
                end
            end
            S_FAC_DIV: begin
                if (div_rem == '0) begin
                    n_f     = div_quo;
                    n_flag  = 1'b1;
                    div_go  = 1'b1;
                    div_num = {{WIDTH{1'b0}}, div_quo};
                    div_den = r_p;
                    n_ret   = S_FAC_DIV;
                    n_state = S_WAIT;
                end else if (r_flag) begin
                    div_go  = 1'b1;
                    div_num = {{WIDTH{1'b0}}, r_phi};
                    div_den = r_p;
                    n_tail  = 1'b0;
                    n_ret   = S_EXP_SET;
                    n_state = S_WAIT;
                end else begin
                    n_p     = r_p + WIDTH'(1);
                    n_state = S_FAC_SQ;
                end
            end
            S_EXP_SET: begin
                n_e     = div_quo;
                n_b     = r_ra;
                n_res   = WIDTH'(1);
                n_state = S_POW_LOOP;
            end
            // square and multiply, each product reduced on the divider
            S_POW_LOOP: begin
                if (r_e == '0) begin
                    if (r_res == WIDTH'(1)) begin
                        n_state = S_FAIL;
                    end else if (r_tail) begin
                        n_state = S_PASS;
                    end else begin
                        n_p     = r_p + WIDTH'(1);
                        n_state = S_FAC_SQ;
                    end
                end else if (r_e[0]) begin
                    mul_x   = r_res;
                    mul_y   = r_b;
                    n_state = S_POW_RM;
                end else begin
                    mul_x   = r_b;
                    mul_y   = r_b;
                    n_state = S_POW_BM;
                end
            end
            S_POW_RM: begin
                div_go  = 1'b1;
                div_num = r_prod;
                div_den = r_n;
                n_ret   = S_POW_RR;
                n_state = S_WAIT;
            end
            S_POW_RR: begin
                n_res   = div_rem;
                mul_x   = r_b;
                mul_y   = r_b;
                n_state = S_POW_BM;
            end
            S_POW_BM: begin
                div_go  = 1'b1;
                div_num = r_prod;
                div_den = r_n;
                n_ret   = S_POW_BR;
                n_state = S_WAIT;
            end
            S_POW_BR: begin
                n_b     = div_rem;
                n_e     = r_e >> 1;
                n_state = S_POW_LOOP;
            end
            S_PASS: begin
                if (r_func) begin
                    n_gen = r_a;
                end else begin
                    n_is_gen = 1'b1;
                end
                n_valid = 1'b1;
                n_state = S_IDLE;
            end
            S_FAIL: begin
                if (r_func) begin
                    n_a     = r_a + WIDTH'(1);
                    n_state = S_SRCH_NEXT;
                end else begin
                    n_is_gen = 1'b0;
                    n_valid  = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            S_WAIT: begin
                if (div_stat.done) begin
                    n_state = r_ret;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
        end
        r_ret    <= n_ret;
        r_func   <= n_func;
        r_n      <= n_n;
        r_a      <= n_a;
        r_phi    <= n_phi;
        r_f      <= n_f;
        r_p      <= n_p;
        r_flag   <= n_flag;
        r_tail   <= n_tail;
        r_x      <= n_x;
        r_y      <= n_y;
        r_ra     <= n_ra;
        r_b      <= n_b;
        r_e      <= n_e;
        r_res    <= n_res;
        r_prod   <= mul_out;
        r_is_gen <= n_is_gen;
        r_gen    <= n_gen;
    end

    assign busy        = (r_state != S_IDLE);
    assign o_valid     = r_valid;
    assign o_is_gen    = r_is_gen;
    assign o_generator = r_gen;
    assign o_totient   = r_phi;

`ifndef SYNTHESIS
    a_valid_from_verdict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ($past(r_state) == S_PASS || $past(r_state) == S_FAIL ||
                     $past(r_state) == S_SRCH_NEXT))
        else $error("result beat without a verdict");
    a_mode_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_is_gen && (o_generator != '0)))
        else $error("is_gen and generator both set");
    a_div_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_go |-> !div_stat.busy)
        else $error("divider restarted while busy");
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted beat did not raise busy");
    a_valid_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("result beat while busy");
`endif

endmodule

/* verif/primitive_root_search_test.sv */
module primitive_root_search_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WIDTH = 16;
    // sender idle percentage changes after the first and the second PHASE_LEN items, then stays at zero
    localparam int PHASE_LEN = 40;

    typedef enum bit {
        FUNC_TEST   = 1'b0,
        FUNC_SEARCH = 1'b1
    } t_root_func;

    typedef struct packed {
        logic             is_gen;
        logic [WIDTH-1:0] generator;
        logic [WIDTH-1:0] totient;
    } t_root_answer;

    class root_ledger;
        t_root_answer pending_q[$];
        int unsigned  failures;

        function new();
            failures = 0;
        endfunction

        function longint unsigned gcd_of(longint unsigned x, longint unsigned y);
            longint unsigned t;
            while (y != 0) begin
                t = x % y;
                x = y;
                y = t;
            end
            return x;
        endfunction

        // base already reduced below m, m >= 2
        function longint unsigned power_mod(longint unsigned b, longint unsigned e,
                                            longint unsigned m);
            longint unsigned r;
            r = 1 % m;
            while (e != 0) begin
                if (e[0])
                    r = (r * b) % m;
                b = (b * b) % m;
                e = e >> 1;
            end
            return r;
        endfunction

        function longint unsigned euler_phi(longint unsigned n);
            longint unsigned r;
            longint unsigned m;
            longint unsigned p;
            if (n < 2)
                return 1;
            r = n;
            m = n;
            for (p = 2; p * p <= m; p++) begin
                if (m % p == 0) begin
                    while (m % p == 0)
                        m = m / p;
                    r = r - r / p;
                end
            end
            if (m > 1)
                r = r - r / m;
            return r;
        endfunction

        // order of a equals phi: no prime q of phi gives a^(phi/q) == 1
        function bit generates(longint unsigned a, longint unsigned n, longint unsigned phi);
            longint unsigned f;
            longint unsigned q;
            if (gcd_of(a, n) != 1)
                return 1'b0;
            if (n < 2)
                return 1'b1;
            a = a % n;
            f = phi;
            for (q = 2; q * q <= f; q++) begin
                if (f % q == 0) begin
                    while (f % q == 0)
                        f = f / q;
                    if (power_mod(a, phi / q, n) == 1)
                        return 1'b0;
                end
            end
            if (f > 1 && power_mod(a, phi / f, n) == 1)
                return 1'b0;
            return 1'b1;
        endfunction

        // a = 1 is never tried, so n = 2 has no root here
        function longint unsigned first_root(longint unsigned n, longint unsigned phi);
            longint unsigned a;
            for (a = 2; a < n; a++) begin
                if (generates(a, n, phi))
                    return a;
            end
            return 0;
        endfunction

        function void note_request(t_root_func func, int unsigned n, int unsigned cand);
            t_root_answer    ans;
            longint unsigned phi;
            phi = euler_phi(64'(n));
            ans = '0;
            ans.totient = phi[WIDTH-1:0];
            if (func == FUNC_TEST)
                ans.is_gen = generates(64'(cand), 64'(n), phi);
            else
                ans.generator = WIDTH'(first_root(64'(n), phi));
            pending_q.push_back(ans);
        endfunction

        function void complain(string what);
            failures++;
            if (failures <= 10)
                $display("%0t: %s", $time, what);
        endfunction

        function void check_answer(logic is_gen, logic [WIDTH-1:0] generator,
                                   logic [WIDTH-1:0] totient);
            t_root_answer want;
            if (pending_q.size() == 0) begin
                complain($sformatf("result with none pending: is_gen %0d generator %0d totient %0d",
                                   is_gen, generator, totient));
                return;
            end
            want = pending_q.pop_front();
            if (is_gen !== want.is_gen)
                complain($sformatf("is_gen: expected %0d, got %0d", want.is_gen, is_gen));
            if (generator !== want.generator)
                complain($sformatf("generator: expected %0d, got %0d",
                                   want.generator, generator));
            if (totient !== want.totient)
                complain($sformatf("totient: expected %0d, got %0d", want.totient, totient));
        endfunction

        function void flush_leftovers();
            t_root_answer want;
            while (pending_q.size() != 0) begin
                want = pending_q.pop_front();
                complain($sformatf("missing result: is_gen %0d generator %0d totient %0d",
                                   want.is_gen, want.generator, want.totient));
            end
        endfunction
    endclass

    logic             i_clk;
    logic             i_rst_n;
    logic             start;
    logic             busy;
    logic             i_func;
    logic [WIDTH-1:0] i_modulus;
    logic [WIDTH-1:0] i_candidate;
    logic             o_valid;
    logic             o_is_gen;
    logic [WIDTH-1:0] o_generator;
    logic [WIDTH-1:0] o_totient;

    root_ledger  ledger;
    int unsigned beats_sent;

    primitive_root_search #(
        .WIDTH(WIDTH)
    ) i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_func      (i_func),
        .i_modulus   (i_modulus),
        .i_candidate (i_candidate),
        .o_valid     (o_valid),
        .o_is_gen    (o_is_gen),
        .o_generator (o_generator),
        .o_totient   (o_totient)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // timeout far above the slowest run, which the search beats on moduli up to 96 dominate
    initial begin
        #(64'd2_000_000_000);
        $display("primitive_root_search: mismatch");
        $finish;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid)
            ledger.check_answer(o_is_gen, o_generator, o_totient);
    end

    task automatic send_request(t_root_func func, int unsigned modulus, int unsigned candidate);
        int unsigned idle_pct;
        idle_pct = (beats_sent < PHASE_LEN) ? 21 : (beats_sent < 2 * PHASE_LEN) ? 73 : 0;
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start       <= 1'b1;
        i_func      <= func;
        i_modulus   <= modulus[WIDTH-1:0];
        i_candidate <= candidate[WIDTH-1:0];
        @(posedge i_clk);
        while (busy)
            @(posedge i_clk);
        ledger.note_request(func, modulus, candidate);
        beats_sent++;
    endtask

    task automatic send_random();
        t_root_func  func;
        int unsigned n;
        int unsigned cand;
        int unsigned root;
        func = t_root_func'($urandom_range(1));
        // search cost grows fast with n, so search stays on small moduli
        if (func == FUNC_SEARCH)
            n = $urandom_range(96, 2);
        else if ($urandom_range(19) == 0)
            n = $urandom_range(1023, 301);
        else
            n = $urandom_range(300, 2);
        case ($urandom_range(3))
            0: cand = $urandom_range(65535);
            1: cand = $urandom_range(n - 1);
            default: begin
                // a known generator (or 1 if none), lifted by a random multiple of n
                root = 32'(ledger.first_root(64'(n), ledger.euler_phi(64'(n))));
                if (root == 0)
                    root = 1;
                cand = root + n * $urandom_range(65535 / n - 1);
            end
        endcase
        send_request(func, n, cand);
    endtask

    initial begin
        ledger     = new();
        beats_sent = 0;
        i_rst_n     <= 1'b0;
        start       <= 1'b0;
        i_func      <= FUNC_TEST;
        i_modulus   <= '0;
        i_candidate <= '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // n = 2: phi is 1, odd candidates generate, search finds nothing
        send_request(FUNC_TEST, 2, 1);
        send_request(FUNC_TEST, 2, 0);
        send_request(FUNC_TEST, 2, 3);
        send_request(FUNC_SEARCH, 2, 65535);
        send_request(FUNC_TEST, 3, 2);
        send_request(FUNC_SEARCH, 3, 0);
        send_request(FUNC_TEST, 7, 3);
        send_request(FUNC_TEST, 7, 2);
        // candidates above the modulus, the first two of them congruent to 1
        send_request(FUNC_TEST, 7, 8);
        send_request(FUNC_TEST, 7, 65535);
        send_request(FUNC_TEST, 11, 13);
        // non-cyclic groups
        send_request(FUNC_TEST, 8, 3);
        send_request(FUNC_SEARCH, 8, 0);
        send_request(FUNC_TEST, 15, 2);
        send_request(FUNC_SEARCH, 15, 0);
        send_request(FUNC_TEST, 256, 3);
        // prime powers and twice prime powers
        send_request(FUNC_TEST, 9, 2);
        send_request(FUNC_SEARCH, 18, 0);
        send_request(FUNC_TEST, 4, 3);
        send_request(FUNC_SEARCH, 4, 0);
        send_request(FUNC_TEST, 10, 10);
        send_request(FUNC_SEARCH, 50, 0);
        send_request(FUNC_TEST, 97, 5);
        // full-width modulus, test mode only: the totient pass alone is long
        send_request(FUNC_TEST, 65535, 65535);

        repeat (76) send_random();
        start <= 1'b0;

        while (ledger.pending_q.size() != 0)
            @(posedge i_clk);
        repeat (1000) @(posedge i_clk);
        ledger.flush_leftovers();
        if (ledger.failures == 0)
            $display("primitive_root_search: match");
        else
            $display("primitive_root_search: mismatch");
        $finish;
    end
endmodule

/* sim.f */
src/prs_pkg.sv
src/prs_divider.sv
src/primitive_root_search.sv
verif/primitive_root_search_test.sv
